@@ rtl/ufd_pkg.sv @@
`default_nettype none

package ufd_pkg;

    localparam logic [7:0]  FLAG_BYTE      = 8'h7E;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [15:0] MIN_LENGTH     = 16'd4;
    localparam logic [15:0] MAX_LENGTH_RST = 16'd256;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC_HI  = 3'd4,
        PH_CRC_LO  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_GOOD    = 2'd1,
        EV_CRC_ERR = 2'd2,
        EV_BAD_LEN = 2'd3
    } t_event_kind;

    typedef struct packed {
        t_event_kind event_kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [15:0] frame_length;
        logic [15:0] received_crc;
        logic [15:0] computed_crc;
    } t_event;

    // byte-wide crc-16-ccitt update, msb first
    function automatic logic [15:0] crc16(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ufd_if.sv @@
`default_nettype none

interface ufd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ufd_event_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [15:0] frame_length;
    logic [15:0] received_crc;
    logic [15:0] computed_crc;

    modport source (output valid, output event_kind, output data_byte, output byte_index,
                    output frame_length, output received_crc, output computed_crc,
                    input ready);
    modport sink (input valid, input event_kind, input data_byte, input byte_index,
                  input frame_length, input received_crc, input computed_crc,
                  output ready);
endinterface

interface ufd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_length;

    modport source (output valid, output max_length, input ready);
    modport sink (input valid, input max_length, output ready);
endinterface

`default_nettype wire

@@ rtl/uart_frame_deframer_crc16.sv @@
`default_nettype none

// Deframer for sync / big-endian length / payload / crc-16-ccitt frames. One received
// byte is taken per clock while the input is ready; each byte transfer updates the
// frame state and the running crc (a byte-wide unrolled crc16 step) in that same
// cycle, and a resulting event is registered in the output buffer. The input stays
// ready unless both entries of the two-entry output buffer are occupied, i.e. it
// stalls only after the event consumer has held off for two results. Payload bytes
// stream out as kind 0 with their index; the last trailer byte yields frame good or
// crc mismatch, and a length outside 4..max_length yields an invalid length event and
// a return to hunting. max_length may only be written while no frame is in progress;
// the cfg channel is always ready.
module uart_frame_deframer_crc16 (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ufd_byte_if.sink      i_rx,
    ufd_event_if.source   o_ev,
    ufd_cfg_if.sink       i_cfg
);

    ufd_pkg::t_phase r_phase;
    ufd_pkg::t_phase n_phase;
    logic [15:0]     r_max_length;
    logic [15:0]     r_length_seen;
    logic [15:0]     n_length_seen;
    logic [15:0]     r_payload_count;
    logic [15:0]     n_payload_count;
    logic [15:0]     r_crc_running;
    logic [15:0]     n_crc_running;
    logic [7:0]      r_trailer_high;
    logic [7:0]      n_trailer_high;

    logic            rx_xfer;
    logic            can_accept;
    logic            push;
    logic            has_event;
    ufd_pkg::t_event new_event;
    ufd_pkg::t_event out_event;
    logic [15:0]     crc_next;
    logic [15:0]     len_full;
    logic [15:0]     count_inc;
    logic [15:0]     rcrc;

    assign i_rx.ready = can_accept;
    assign rx_xfer    = i_rx.valid && can_accept;
    assign push       = rx_xfer && has_event;
    assign i_cfg.ready = 1'b1;

    assign crc_next  = ufd_pkg::crc16(r_crc_running, i_rx.rx_byte);
    assign len_full  = {r_length_seen[15:8], i_rx.rx_byte};
    assign count_inc = r_payload_count + 16'd1;
    assign rcrc      = {r_trailer_high, i_rx.rx_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= ufd_pkg::MAX_LENGTH_RST;
        end else if (i_cfg.valid) begin
            r_max_length <= i_cfg.max_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= ufd_pkg::PH_HUNT;
            r_length_seen   <= '0;
            r_payload_count <= '0;
            r_crc_running   <= ufd_pkg::CRC_INIT;
            r_trailer_high  <= '0;
        end else if (rx_xfer) begin
            r_phase         <= n_phase;
            r_length_seen   <= n_length_seen;
            r_payload_count <= n_payload_count;
            r_crc_running   <= n_crc_running;
            r_trailer_high  <= n_trailer_high;
        end
    end

    always_comb begin
        n_phase         = r_phase;
        n_length_seen   = r_length_seen;
        n_payload_count = r_payload_count;
        n_crc_running   = r_crc_running;
        n_trailer_high  = r_trailer_high;
        has_event       = 1'b0;
        new_event       = '0;
        new_event.frame_length = r_length_seen;
        unique case (r_phase)
            ufd_pkg::PH_LEN_HI: begin
                n_length_seen = {i_rx.rx_byte, 8'h00};
                n_crc_running = crc_next;
                n_phase       = ufd_pkg::PH_LEN_LO;
            end
            ufd_pkg::PH_LEN_LO: begin
                n_length_seen = len_full;
                n_crc_running = crc_next;
                if (len_full < ufd_pkg::MIN_LENGTH || len_full > r_max_length) begin
                    n_phase                = ufd_pkg::PH_HUNT;
                    has_event              = 1'b1;
                    new_event.event_kind   = ufd_pkg::EV_BAD_LEN;
                    new_event.frame_length = len_full;
                end else begin
                    n_payload_count = '0;
                    n_phase         = ufd_pkg::PH_PAYLOAD;
                end
            end
            ufd_pkg::PH_PAYLOAD: begin
                n_crc_running        = crc_next;
                has_event            = 1'b1;
                new_event.event_kind = ufd_pkg::EV_PAYLOAD;
                new_event.data_byte  = i_rx.rx_byte;
                new_event.byte_index = r_payload_count;
                n_payload_count      = count_inc;
                if (count_inc >= r_length_seen) begin
                    n_phase = ufd_pkg::PH_CRC_HI;
                end
            end
            ufd_pkg::PH_CRC_HI: begin
                n_trailer_high = i_rx.rx_byte;
                n_phase        = ufd_pkg::PH_CRC_LO;
            end
            ufd_pkg::PH_CRC_LO: begin
                has_event              = 1'b1;
                new_event.event_kind   = (rcrc == r_crc_running) ? ufd_pkg::EV_GOOD
                                                                 : ufd_pkg::EV_CRC_ERR;
                new_event.received_crc = rcrc;
                new_event.computed_crc = r_crc_running;
                n_phase                = ufd_pkg::PH_HUNT;
            end
            default: begin
                // hunting; a sync byte starts a new frame
                n_phase = ufd_pkg::PH_HUNT;
                if (i_rx.rx_byte == ufd_pkg::FLAG_BYTE) begin
                    n_phase         = ufd_pkg::PH_LEN_HI;
                    n_crc_running   = ufd_pkg::CRC_INIT;
                    n_payload_count = '0;
                end
            end
        endcase
    end

    ufd_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_event      (new_event),
        .o_can_accept (can_accept),
        .o_valid      (o_ev.valid),
        .o_event      (out_event),
        .i_ready      (o_ev.ready)
    );

    assign o_ev.event_kind   = out_event.event_kind;
    assign o_ev.data_byte    = out_event.data_byte;
    assign o_ev.byte_index   = out_event.byte_index;
    assign o_ev.frame_length = out_event.frame_length;
    assign o_ev.received_crc = out_event.received_crc;
    assign o_ev.computed_crc = out_event.computed_crc;

`ifndef SYNTHESIS
    a_verdict_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_xfer && r_phase == ufd_pkg::PH_CRC_LO) |=> o_ev.valid)
        else $error("frame verdict was not queued");

    a_payload_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == ufd_pkg::PH_PAYLOAD) |-> (r_payload_count < r_length_seen))
        else $error("payload count ran past frame length");

    a_stall_has_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rx.ready |-> o_ev.valid)
        else $error("input stalled with no pending event");
`endif

endmodule

`default_nettype wire

@@ rtl/ufd_out_buf.sv @@
`default_nettype none

// two-entry output buffer: output register plus skid register
module ufd_out_buf (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire ufd_pkg::t_event i_event,
    output logic                 o_can_accept,
    output logic                 o_valid,
    output ufd_pkg::t_event      o_event,
    input  wire logic            i_ready
);

    logic            r_out_valid;
    logic            r_skd_valid;
    ufd_pkg::t_event r_out;
    ufd_pkg::t_event r_skd;
    logic            pop;

    assign pop          = r_out_valid && i_ready;
    assign o_can_accept = !r_skd_valid;
    assign o_valid      = r_out_valid;
    assign o_event      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (r_skd_valid) begin
            // no push can arrive while the skid entry is held
            if (pop) begin
                r_skd_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skd_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_valid) begin
            if (pop) begin
                r_out <= r_skd;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skd <= i_event;
            end else begin
                r_out <= i_event;
            end
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_uart_frame_deframer_crc16.sv @@
`timescale 1ns / 100ps

module tb_uart_frame_deframer_crc16;

    typedef enum logic [1:0] {
        ROW_LIT,
        ROW_CRC_HI,
        ROW_CRC_HI_BAD,
        ROW_CRC_LO
    } t_row_kind;

    typedef struct {
        t_row_kind       kind;
        logic [7:0]      value;
        bit              typed;
        ufd_pkg::t_event want;
    } t_stim_row;

    localparam int PHASE_ITEMS = 190;
    localparam int N_ROWS      = 28;

    logic clk = 1'b0;
    logic rst_n;

    ufd_byte_if  rx_if ();
    ufd_event_if ev_if ();
    ufd_cfg_if   cfg_if ();

    uart_frame_deframer_crc16 dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_if),
        .o_ev    (ev_if),
        .i_cfg   (cfg_if)
    );

    always #5 clk = ~clk;

    // deframer state mirrored by the testbench
    ufd_pkg::t_phase frame_ph;
    logic [15:0]     max_len;
    logic [15:0]     len_seen;
    logic [15:0]     pay_cnt;
    logic [15:0]     crc_run;
    logic [7:0]      trl_hi;

    ufd_pkg::t_event expected_events[$];
    ufd_pkg::t_event got_ev;
    ufd_pkg::t_event want_ev;
    int     errors = 0;
    int     bytes_sent = 0;
    bit     no_idle = 1'b0;
    bit     last_had_event;

    function automatic logic [15:0] crc_ccitt_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        int          i;
        c = crc;
        for (i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0} ^ (fb ? ufd_pkg::CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // advances the mirrored state by one byte, returns 1 when the byte yields an event
    function automatic bit deframe_byte(input logic [7:0] b, output ufd_pkg::t_event ev);
        logic [15:0] rcv;
        bit          hit;
        ev = '0;
        hit = 1'b0;
        case (frame_ph)
            ufd_pkg::PH_LEN_HI: begin
                len_seen = {b, 8'h00};
                crc_run = crc_ccitt_next(crc_run, b);
                frame_ph = ufd_pkg::PH_LEN_LO;
            end
            ufd_pkg::PH_LEN_LO: begin
                len_seen = {len_seen[15:8], b};
                crc_run = crc_ccitt_next(crc_run, b);
                if (len_seen < ufd_pkg::MIN_LENGTH || len_seen > max_len) begin
                    frame_ph = ufd_pkg::PH_HUNT;
                    ev.event_kind = ufd_pkg::EV_BAD_LEN;
                    ev.frame_length = len_seen;
                    hit = 1'b1;
                end else begin
                    pay_cnt = '0;
                    frame_ph = ufd_pkg::PH_PAYLOAD;
                end
            end
            ufd_pkg::PH_PAYLOAD: begin
                crc_run = crc_ccitt_next(crc_run, b);
                ev.event_kind = ufd_pkg::EV_PAYLOAD;
                ev.data_byte = b;
                ev.byte_index = pay_cnt;
                ev.frame_length = len_seen;
                hit = 1'b1;
                pay_cnt = pay_cnt + 16'd1;
                if (pay_cnt >= len_seen) begin
                    frame_ph = ufd_pkg::PH_CRC_HI;
                end
            end
            ufd_pkg::PH_CRC_HI: begin
                trl_hi = b;
                frame_ph = ufd_pkg::PH_CRC_LO;
            end
            ufd_pkg::PH_CRC_LO: begin
                rcv = {trl_hi, b};
                ev.event_kind = (rcv == crc_run) ? ufd_pkg::EV_GOOD : ufd_pkg::EV_CRC_ERR;
                ev.frame_length = len_seen;
                ev.received_crc = rcv;
                ev.computed_crc = crc_run;
                hit = 1'b1;
                frame_ph = ufd_pkg::PH_HUNT;
            end
            default: begin
                frame_ph = ufd_pkg::PH_HUNT;
                if (b == ufd_pkg::FLAG_BYTE) begin
                    frame_ph = ufd_pkg::PH_LEN_HI;
                    crc_run = ufd_pkg::CRC_INIT;
                    pay_cnt = '0;
                end
            end
        endcase
        return hit;
    endfunction

    function automatic ufd_pkg::t_event bad_len_event(input logic [15:0] len);
        ufd_pkg::t_event ev;
        ev = '0;
        ev.event_kind = ufd_pkg::EV_BAD_LEN;
        ev.frame_length = len;
        return ev;
    endfunction

    function automatic logic [7:0] payload_byte();
        return ($urandom_range(0, 9) == 0) ? ufd_pkg::FLAG_BYTE : 8'($urandom);
    endfunction

    // anything but the sync byte, so hunting stays in hunting
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 254));
        if (b >= ufd_pkg::FLAG_BYTE) begin
            b = b + 8'd1;
        end
        return b;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (errors < 40) begin
            $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
        end
        errors++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        ufd_pkg::t_event ev;
        if (!no_idle && $urandom_range(0, 9) == 0) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge clk); while (!rx_if.ready);
        bytes_sent++;
        last_had_event = deframe_byte(b, ev);
        if (last_had_event) begin
            expected_events.push_back(ev);
        end
    endtask

    task automatic finish_frame();
        while (frame_ph != ufd_pkg::PH_HUNT) begin
            send_byte((frame_ph inside {ufd_pkg::PH_LEN_HI, ufd_pkg::PH_LEN_LO})
                      ? 8'h00 : 8'($urandom));
        end
    endtask

    task automatic drain_events();
        rx_if.valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_max_length(input logic [15:0] v);
        finish_frame();
        drain_events();
        cfg_if.valid <= 1'b1;
        cfg_if.max_length <= v;
        do @(posedge clk); while (!cfg_if.ready);
        max_len = v;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_frame(input logic [15:0] len, input int n_payload, input bit bad_crc);
        logic [15:0] trailer;
        int          i;
        send_byte(ufd_pkg::FLAG_BYTE);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        for (i = 0; i < n_payload && frame_ph == ufd_pkg::PH_PAYLOAD; i++) begin
            send_byte(payload_byte());
        end
        if (frame_ph == ufd_pkg::PH_CRC_HI) begin
            trailer = bad_crc ? crc_run ^ (16'h0001 << $urandom_range(0, 15)) : crc_run;
            send_byte(trailer[15:8]);
            send_byte(trailer[7:0]);
        end
    endtask

    task automatic run_random_phase(input int budget);
        int          stop_at;
        int          pick;
        int          hi;
        logic [15:0] len;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            // with large limits a stray header could open a huge frame, so start clean
            if (max_len > 16'd64) begin
                finish_frame();
            end
            pick = $urandom_range(0, 9);
            hi = (max_len < ufd_pkg::MIN_LENGTH) ? 12
               : ((max_len > 16'd24) ? 24 : int'(max_len));
            len = 16'($urandom_range(4, hi));
            if (max_len >= ufd_pkg::MIN_LENGTH && max_len <= 16'd300
                && $urandom_range(0, 7) == 0) begin
                len = max_len;
            end else if ($urandom_range(0, 7) == 0) begin
                len = ufd_pkg::MIN_LENGTH;
            end
            case (pick)
                6: send_frame(len, len, 1'b1);
                7: begin
                    if (max_len < 16'hFFFF && $urandom_range(0, 1) == 1) begin
                        len = ($urandom_range(0, 1) == 1) ? max_len + 16'd1
                            : 16'($urandom_range(int'(max_len) + 1, 65535));
                    end else begin
                        len = 16'($urandom_range(0, 3));
                    end
                    send_frame(len, 0, 1'b0);
                end
                8: repeat ($urandom_range(1, 6)) send_byte(noise_byte());
                9: send_frame(len, $urandom_range(0, int'(len) - 1), 1'b0);
                default: send_frame(len, len, 1'b0);
            endcase
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && ev_if.valid && ev_if.ready) begin
            got_ev.event_kind = ufd_pkg::t_event_kind'(ev_if.event_kind);
            got_ev.data_byte = ev_if.data_byte;
            got_ev.byte_index = ev_if.byte_index;
            got_ev.frame_length = ev_if.frame_length;
            got_ev.received_crc = ev_if.received_crc;
            got_ev.computed_crc = ev_if.computed_crc;
            if (expected_events.size() == 0) begin
                report_mismatch("event with none pending, kind",
                                16'(got_ev.event_kind), 16'h0000);
            end else begin
                want_ev = expected_events.pop_front();
                if (got_ev.event_kind !== want_ev.event_kind)
                    report_mismatch("event_kind", 16'(got_ev.event_kind),
                                    16'(want_ev.event_kind));
                if (got_ev.data_byte !== want_ev.data_byte)
                    report_mismatch("data_byte", 16'(got_ev.data_byte),
                                    16'(want_ev.data_byte));
                if (got_ev.byte_index !== want_ev.byte_index)
                    report_mismatch("byte_index", got_ev.byte_index, want_ev.byte_index);
                if (got_ev.frame_length !== want_ev.frame_length)
                    report_mismatch("frame_length", got_ev.frame_length, want_ev.frame_length);
                if (got_ev.received_crc !== want_ev.received_crc)
                    report_mismatch("received_crc", got_ev.received_crc, want_ev.received_crc);
                if (got_ev.computed_crc !== want_ev.computed_crc)
                    report_mismatch("computed_crc", got_ev.computed_crc, want_ev.computed_crc);
            end
        end
    end

    // event consumer with random stall bursts
    initial begin
        ev_if.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (!no_idle && $urandom_range(0, 3) == 0) begin
                ev_if.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            ev_if.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    end

    initial begin
        #10ms;
        $display("simulation failed");
        $finish;
    end

    initial begin
        t_stim_row rows [N_ROWS];
        rst_n <= 1'b0;
        rx_if.valid <= 1'b0;
        rx_if.rx_byte <= 8'h00;
        cfg_if.valid <= 1'b0;
        cfg_if.max_length <= 16'h0000;
        frame_ph = ufd_pkg::PH_HUNT;
        max_len = ufd_pkg::MAX_LENGTH_RST;
        len_seen = '0;
        pay_cnt = '0;
        crc_run = ufd_pkg::CRC_INIT;
        trl_hi = '0;

        rows = '{
            '{ROW_LIT, 8'h00, 1'b0, '0},
            '{ROW_LIT, 8'h7E, 1'b0, '0},
            '{ROW_LIT, 8'h00, 1'b0, '0},
            '{ROW_LIT, 8'h00, 1'b1, bad_len_event(16'h0000)},
            '{ROW_LIT, 8'h7E, 1'b0, '0},
            '{ROW_LIT, 8'hFF, 1'b0, '0},
            '{ROW_LIT, 8'hFF, 1'b1, bad_len_event(16'hFFFF)},
            '{ROW_LIT, 8'h7E, 1'b0, '0},
            '{ROW_LIT, 8'h01, 1'b0, '0},
            '{ROW_LIT, 8'h01, 1'b1, bad_len_event(16'h0101)},
            // shortest good frame, sync value carried as payload
            '{ROW_LIT, 8'h7E, 1'b0, '0},
            '{ROW_LIT, 8'h00, 1'b0, '0},
            '{ROW_LIT, 8'h04, 1'b0, '0},
            '{ROW_LIT, 8'h7E, 1'b0, '0},
            '{ROW_LIT, 8'h00, 1'b0, '0},
            '{ROW_LIT, 8'hFF, 1'b0, '0},
            '{ROW_LIT, 8'h80, 1'b0, '0},
            '{ROW_CRC_HI, 8'h00, 1'b0, '0},
            '{ROW_CRC_LO, 8'h00, 1'b0, '0},
            // same length, corrupted trailer
            '{ROW_LIT, 8'h7E, 1'b0, '0},
            '{ROW_LIT, 8'h00, 1'b0, '0},
            '{ROW_LIT, 8'h04, 1'b0, '0},
            '{ROW_LIT, 8'h01, 1'b0, '0},
            '{ROW_LIT, 8'h02, 1'b0, '0},
            '{ROW_LIT, 8'h03, 1'b0, '0},
            '{ROW_LIT, 8'h04, 1'b0, '0},
            '{ROW_CRC_HI_BAD, 8'h00, 1'b0, '0},
            '{ROW_CRC_LO, 8'h00, 1'b0, '0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i]) begin
            case (rows[i].kind)
                ROW_CRC_HI:     send_byte(crc_run[15:8]);
                ROW_CRC_HI_BAD: send_byte(~crc_run[15:8]);
                ROW_CRC_LO:     send_byte(crc_run[7:0]);
                default:        send_byte(rows[i].value);
            endcase
            if (rows[i].typed) begin
                if (last_had_event)
                    expected_events[expected_events.size() - 1] = rows[i].want;
                else
                    expected_events.push_back(rows[i].want);
            end
        end

        run_random_phase(PHASE_ITEMS);
        set_max_length(ufd_pkg::MIN_LENGTH);
        run_random_phase(PHASE_ITEMS);
        set_max_length(16'd0);
        run_random_phase(PHASE_ITEMS);
        set_max_length(16'hFFFF);
        run_random_phase(PHASE_ITEMS);
        set_max_length(16'd5);
        run_random_phase(PHASE_ITEMS);
        set_max_length(16'd1000);
        run_random_phase(PHASE_ITEMS);
        set_max_length(16'($urandom_range(4, 65535)));
        run_random_phase(PHASE_ITEMS);
        set_max_length(16'd3);
        run_random_phase(PHASE_ITEMS);
        set_max_length(16'd40);
        no_idle = 1'b1;
        run_random_phase(PHASE_ITEMS);
        drain_events();
        repeat (4) @(posedge clk);

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
